// File: rtl/lebcs_pkg.sv
// lebcs_pkg: shared types, codes and constants for the led blink-code sequencer
// used by lebcs_seq, led_error_blink_code_sequencer_core and lebcs_checker
// depends on nothing

package lebcs_pkg;

    // group length saturates here
    localparam int unsigned MAX_BLINKS = 15;
    localparam int unsigned US_PER_MS  = 1000;

    localparam int unsigned MS_W       = 16;
    // 65535 ms * 1000 fits in 26 bits
    localparam int unsigned DUR_W      = 26;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CODE_W     = 4;
    localparam int unsigned GROUP_W    = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME = 2'd2;

    typedef logic [DUR_W-1:0] t_dur_us;

    localparam t_dur_us ON_RST_US  = t_dur_us'(250 * 1000);
    localparam t_dur_us OFF_RST_US = t_dur_us'(250 * 1000);
    localparam t_dur_us GAP_RST_US = t_dur_us'(1000 * 1000);

    typedef enum logic [1:0] {
        MODE_POLL   = 2'd0,
        MODE_DRIVE  = 2'd1,
        MODE_MANUAL = 2'd2,
        MODE_ERROR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LIT  = 2'd1,
        PH_DARK = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    typedef struct packed {
        t_mode              mode;
        logic               flag_value;
        logic [CODE_W-1:0]  error_code;
        logic [TIME_W-1:0]  now_us;
    } t_event;

    typedef struct packed {
        logic               drive_active;
        logic               manual_on;
        logic [CODE_W-1:0]  active_error;
        t_phase             phase;
        logic [CODE_W-1:0]  blinks_done;
        logic [TIME_W-1:0]  phase_start_us;
        logic               previous_level;
    } t_seq_state;

    typedef struct packed {
        t_dur_us on_us;
        t_dur_us off_us;
        t_dur_us gap_us;
    } t_durations;

    localparam t_seq_state SEQ_RST = '{
        drive_active:   1'b0,
        manual_on:      1'b0,
        active_error:   '0,
        phase:          PH_IDLE,
        blinks_done:    '0,
        phase_start_us: '0,
        previous_level: 1'b0
    };

    localparam t_durations DUR_RST = '{
        on_us:  ON_RST_US,
        off_us: OFF_RST_US,
        gap_us: GAP_RST_US
    };

    // milliseconds to microseconds, product fits in DUR_W
    function automatic t_dur_us ms_to_us(input logic [MS_W-1:0] ms);
        return t_dur_us'(ms) * t_dur_us'(US_PER_MS);
    endfunction

endpackage

// File: rtl/lebcs_seq.sv
// lebcs_seq: next-state logic of the blink-code sequencer for one event
// depends on lebcs_pkg

module lebcs_seq (
    input  lebcs_pkg::t_seq_state i_state,
    input  lebcs_pkg::t_event     i_event,
    input  lebcs_pkg::t_durations i_dur,
    output lebcs_pkg::t_seq_state o_state,
    output logic                  o_level,
    output logic                  o_changed
);

    lebcs_pkg::t_seq_state s;
    lebcs_pkg::t_dur_us    dur;
    logic [lebcs_pkg::TIME_W-1:0]  delta;
    logic                          done;
    logic [lebcs_pkg::GROUP_W-1:0] group;
    logic [lebcs_pkg::CODE_W-1:0]  blinks_inc;
    logic                          level;

    always_comb begin
        s = i_state;

        // flag and code writes come before the update
        unique case (i_event.mode)
            lebcs_pkg::MODE_DRIVE:  s.drive_active = i_event.flag_value;
            lebcs_pkg::MODE_MANUAL: s.manual_on    = i_event.flag_value;
            lebcs_pkg::MODE_ERROR:  s.active_error = i_event.error_code;
            default: ;
        endcase

        case (s.phase)
            lebcs_pkg::PH_LIT:  dur = i_dur.on_us;
            lebcs_pkg::PH_DARK: dur = i_dur.off_us;
            default:            dur = i_dur.gap_us;
        endcase

        // wrapping elapsed time
        delta = i_event.now_us - s.phase_start_us;
        done  = (delta >= lebcs_pkg::TIME_W'(dur));

        if (lebcs_pkg::GROUP_W'(s.active_error) > lebcs_pkg::GROUP_W'(lebcs_pkg::MAX_BLINKS)) begin
            group = lebcs_pkg::GROUP_W'(lebcs_pkg::MAX_BLINKS);
        end else begin
            group = lebcs_pkg::GROUP_W'(s.active_error);
        end

        blinks_inc = s.blinks_done + 1'b1;

        if (s.active_error == '0) begin
            s.phase = lebcs_pkg::PH_IDLE;
            level   = s.drive_active | s.manual_on;
        end else begin
            unique case (s.phase)
                lebcs_pkg::PH_IDLE: begin
                    s.phase          = lebcs_pkg::PH_LIT;
                    s.blinks_done    = '0;
                    s.phase_start_us = i_event.now_us;
                end
                lebcs_pkg::PH_LIT: begin
                    if (done) begin
                        s.phase          = lebcs_pkg::PH_DARK;
                        s.phase_start_us = i_event.now_us;
                    end
                end
                lebcs_pkg::PH_DARK: begin
                    if (done) begin
                        s.blinks_done    = blinks_inc;
                        s.phase          = (lebcs_pkg::GROUP_W'(blinks_inc) >= group)
                                           ? lebcs_pkg::PH_GAP : lebcs_pkg::PH_LIT;
                        s.phase_start_us = i_event.now_us;
                    end
                end
                default: begin
                    if (done) begin
                        s.phase          = lebcs_pkg::PH_LIT;
                        s.blinks_done    = '0;
                        s.phase_start_us = i_event.now_us;
                    end
                end
            endcase
            level = (s.phase == lebcs_pkg::PH_LIT);
        end

        o_changed        = (level != i_state.previous_level);
        s.previous_level = level;
        o_level          = level;
        o_state          = s;
    end

endmodule

// File: rtl/led_error_blink_code_sequencer_core.sv
// led_error_blink_code_sequencer_core: top level of the led blink-code error indicator
// depends on lebcs_pkg and lebcs_seq

// usage
//   slave stream carries one event per request: tuser holds the mode, tdata the
//   flag level, error code and microsecond timestamp. master stream returns one
//   result per event: led level and a changed flag.
//   the config port writes on, off and gap times in ms; each write is converted
//   to microseconds on the spot, so write it only while no event is in flight.
// timing
//   an accepted event is held in the input register, then the sequencer
//   update runs as one subtract and compare into the result register, which
//   drives the master side. throughput is one event per cycle while the
//   master side is not stalled.
// reset
//   synchronous active low; flags, error code and sequencer return to idle and
//   dark, and the durations go back to 250 / 250 / 1000 ms.
// stalls
//   while the master side is stalled the result register holds; if the input
//   register is empty one more event is taken into it, after which tready drops.

module led_error_blink_code_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] flag_value, [4:1] error_code, [36:5] now_us, [39:37] zero
    input  logic [lebcs_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                        i_s_axis_tuser,
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] led_level, [1] led_changed, [7:2] zero
    output logic [lebcs_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [lebcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lebcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // input register
    logic                  r_in_valid;
    lebcs_pkg::t_event     r_event;

    // result register
    logic                  r_out_valid;
    logic                  r_out_level;
    logic                  r_out_changed;

    // sequencer state and durations in microseconds
    lebcs_pkg::t_seq_state r_state;
    lebcs_pkg::t_seq_state n_state;
    lebcs_pkg::t_durations r_dur;
    logic                  n_out_level;
    logic                  n_out_changed;

    logic                  w_advance;
    logic                  w_in_take;
    logic                  w_step;

    // result register free or being emptied this cycle
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_step          = r_in_valid && w_advance;

    lebcs_seq u_seq (
        .i_state   (r_state),
        .i_event   (r_event),
        .i_dur     (r_dur),
        .o_state   (n_state),
        .o_level   (n_out_level),
        .o_changed (n_out_changed)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= lebcs_pkg::SEQ_RST;
            r_dur       <= lebcs_pkg::DUR_RST;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lebcs_pkg::CFG_ON_TIME:  r_dur.on_us  <= lebcs_pkg::ms_to_us(i_cfg_data);
                    lebcs_pkg::CFG_OFF_TIME: r_dur.off_us <= lebcs_pkg::ms_to_us(i_cfg_data);
                    lebcs_pkg::CFG_GAP_TIME: r_dur.gap_us <= lebcs_pkg::ms_to_us(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_event.mode       <= lebcs_pkg::t_mode'(i_s_axis_tuser);
            r_event.flag_value <= i_s_axis_tdata[0];
            r_event.error_code <= i_s_axis_tdata[4:1];
            r_event.now_us     <= i_s_axis_tdata[36:5];
        end
        if (w_step) begin
            r_out_level   <= n_out_level;
            r_out_changed <= n_out_changed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_changed, r_out_level};

endmodule

// File: rtl/lebcs_checker.sv
// lebcs_checker: port-level assertions for the blink-code sequencer top level
// depends on lebcs_pkg; bound to led_error_blink_code_sequencer_core below

module lebcs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [lebcs_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    // level of the last result handed over
    logic r_last_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_last_level <= o_m_axis_tdata[0];
        end
    end

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // no result straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // changed flag tracks the previous delivered level
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1] == (o_m_axis_tdata[0] != r_last_level)))
        else $error("changed flag inconsistent with previous level");

    // input back-pressure only comes from a stalled full result side
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output back-pressure");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:2] == 6'b0))
        else $error("result padding not zero");

endmodule

bind led_error_blink_code_sequencer_core lebcs_checker u_lebcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
